### design/crd_pkg.sv
// shared types, codes and the crc-32 byte update for the record deframer
package crd_pkg;

   localparam int unsigned LEN_W = 26;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] HARD_MAX_LEN = 32'd33554432;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 26'd33554432;

   localparam logic FUNC_DATA = 1'b0;
   localparam logic FUNC_END = 1'b1;

   localparam logic [2:0] STATUS_BUSY = 3'd0;
   localparam logic [2:0] STATUS_GOOD = 3'd1;
   localparam logic [2:0] STATUS_CRC_ERR = 3'd2;
   localparam logic [2:0] STATUS_BAD_LEN = 3'd3;
   localparam logic [2:0] STATUS_TRUNC = 3'd4;
   localparam logic [2:0] STATUS_END = 3'd5;

   localparam logic [2:0] HDR_LAST = 3'd7;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_ERROR = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic payload_valid;
      logic last;
      logic [2:0] status;
      logic [LEN_W-1:0] record_length;
   } result_type;

   // reflected crc-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### design/crd_core.sv
// header parse, length check, crc accumulation and verdict for one request
module crd_core
   import crd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic func,
   input  logic [7:0] data_byte,
   input  logic csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data,
   output logic res_valid,
   output result_type res
);

   phase_type phase_ff, phase_in;
   logic [2:0] header_count_ff, header_count_in;
   logic [31:0] header_length_ff, header_length_in;
   logic [31:0] expected_crc_ff, expected_crc_in;
   logic [31:0] running_crc_ff, running_crc_in;
   logic [LEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic [LEN_W-1:0] max_len_ff;

   logic [31:0] crc_next;
   logic [LEN_W-1:0] left_next;
   logic len_bad;
   logic crc_ok;

   assign crc_next = crc32_byte(running_crc_ff, data_byte);
   assign left_next = bytes_left_ff - 1'b1;
   assign crc_ok = ((crc_next ^ CRC_INIT) == expected_crc_ff);
   assign len_bad = (header_length_ff == 32'd0)
                    || (header_length_ff > {6'd0, max_len_ff})
                    || (header_length_ff > HARD_MAX_LEN);

   // next state
   always_comb begin
      phase_in = phase_ff;
      header_count_in = header_count_ff;
      header_length_in = header_length_ff;
      expected_crc_in = expected_crc_ff;
      running_crc_in = running_crc_ff;
      bytes_left_in = bytes_left_ff;
      if (func == FUNC_END) begin
         phase_in = PH_HEADER;
         header_count_in = 3'd0;
         header_length_in = 32'd0;
         expected_crc_in = 32'd0;
         running_crc_in = CRC_INIT;
         bytes_left_in = '0;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (!header_count_ff[2]) begin
                  header_length_in = {data_byte, header_length_ff[31:8]};
               end else begin
                  expected_crc_in = {data_byte, expected_crc_ff[31:8]};
               end
               if (header_count_ff != HDR_LAST) begin
                  header_count_in = header_count_ff + 3'd1;
               end else begin
                  header_count_in = 3'd0;
                  if (len_bad) begin
                     phase_in = PH_ERROR;
                  end else begin
                     phase_in = PH_PAYLOAD;
                     bytes_left_in = header_length_ff[LEN_W-1:0];
                     running_crc_in = CRC_INIT;
                  end
               end
            end
            PH_PAYLOAD: begin
               running_crc_in = crc_next;
               bytes_left_in = left_next;
               if (left_next == '0) begin
                  if (crc_ok) begin
                     phase_in = PH_HEADER;
                     header_count_in = 3'd0;
                     header_length_in = 32'd0;
                     expected_crc_in = 32'd0;
                     running_crc_in = CRC_INIT;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result
   always_comb begin
      res_valid = 1'b0;
      res.payload_byte = 8'd0;
      res.payload_valid = 1'b0;
      res.last = 1'b0;
      res.status = STATUS_BUSY;
      res.record_length = '0;
      if (func == FUNC_END) begin
         unique case (phase_ff)
            PH_HEADER: begin
               res_valid = accept;
               res.last = 1'b1;
               res.status = (header_count_ff == 3'd0) ? STATUS_END : STATUS_TRUNC;
            end
            PH_PAYLOAD: begin
               res_valid = accept;
               res.last = 1'b1;
               res.status = STATUS_TRUNC;
               res.record_length = header_length_ff[LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (header_count_ff == HDR_LAST && len_bad) begin
                  res_valid = accept;
                  res.last = 1'b1;
                  res.status = STATUS_BAD_LEN;
                  res.record_length = header_length_ff[LEN_W-1:0];
               end
            end
            PH_PAYLOAD: begin
               res_valid = accept;
               res.payload_byte = data_byte;
               res.payload_valid = 1'b1;
               res.record_length = header_length_ff[LEN_W-1:0];
               if (left_next == '0) begin
                  res.last = 1'b1;
                  res.status = crc_ok ? STATUS_GOOD : STATUS_CRC_ERR;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         header_count_ff <= 3'd0;
         header_length_ff <= 32'd0;
         expected_crc_ff <= 32'd0;
         running_crc_ff <= CRC_INIT;
         bytes_left_ff <= '0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            header_count_ff <= header_count_in;
            header_length_ff <= header_length_in;
            expected_crc_ff <= expected_crc_in;
            running_crc_ff <= running_crc_in;
            bytes_left_ff <= bytes_left_in;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

endmodule

### design/crd_skid.sv
// result register with one skid entry so one more result can be taken during a stall
module crd_skid
   import crd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  result_type push_data,
   output logic full,
   output logic out_valid,
   input  logic out_ready,
   output result_type out_data
);

   logic out_valid_ff;
   logic skid_valid_ff;
   result_type out_ff;
   result_type skid_ff;
   logic pop;

   assign pop = out_valid_ff && out_ready;
   assign full = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            out_ff <= push_data;
         end
      end
   end

endmodule

### design/crc32_record_deframer.sv
// top level of the length-prefixed record deframer with crc-32 check
//
// req channel carries the journal stream one byte per request: tdata is the
// byte, tuser is 1 for the end-of-stream marker. each record is an 8-byte
// header (le payload length, le reflected crc-32 of the payload) followed by
// the payload. rsp channel returns at most one result per request: payload
// bytes as they pass, the verdict on the last one, a bad-length verdict right
// after the header and a clean-end or truncated verdict for the end marker.
// after an error, bytes are dropped until the end marker.
// csr_wr_en/csr_wr_data set the largest accepted payload length.
// a result is registered (result register, or skid entry while rsp stalls);
// one request per cycle is sustained while rsp takes results, the crc byte
// update and length compare sit between the state and result registers.
// reset clears the parser to the header phase and sets the max length to
// 33554432. when rsp stalls, one more result is held in a skid entry, then
// req_tready drops until the receiver takes a result.
module crc32_record_deframer
   import crd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,      // [7:0] data_byte
   input  logic [0:0] req_tuser,      // [0] func
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata,     // [7:0] payload_byte, [33:8] record_length
   output logic rsp_tlast,            // last
   output logic [3:0] rsp_tuser,      // [0] payload_valid, [3:1] status
   input  logic csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   logic accept;
   logic res_valid;
   logic full;
   result_type res;
   result_type out_data;

   assign req_tready = !full;
   assign accept = req_tvalid && req_tready;

   crd_core u_core (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .func(req_tuser[0]),
      .data_byte(req_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .res_valid(res_valid),
      .res(res)
   );

   crd_skid u_skid (
      .clock(clock),
      .reset(reset),
      .push(res_valid),
      .push_data(res),
      .full(full),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data(out_data)
   );

   assign rsp_tdata = {6'd0, out_data.record_length, out_data.payload_byte};
   assign rsp_tlast = out_data.last;
   assign rsp_tuser = {out_data.status, out_data.payload_valid};

endmodule

### tb/testbench.sv
// record deframer testbench: crc-32 record streams checked against a predictor
`timescale 1ns / 100ps

module testbench
   import crd_pkg::*;
();

   typedef enum {REC_GOOD, REC_BAD_CRC, REC_CUT_SHORT} record_kind_type;

   localparam int unsigned ITEMS_PER_SETTING = 275;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned DRAIN_CYCLES = 5;

   // predicts deframer verdicts and holds the results still owed by the block
   class record_scoreboard;
      logic [LEN_W-1:0] max_len;
      phase_type phase;
      logic [2:0] hdr_count;
      logic [31:0] hdr_len;
      logic [31:0] hdr_crc;
      logic [31:0] crc;
      logic [LEN_W-1:0] left;
      result_type pending[$];
      int errors;

      function new();
         max_len = MAX_LEN_RESET;
         errors = 0;
         restart();
      endfunction

      static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c;
         for (int k = 0; k < 8; k++)
            r = (r[0] ^ b[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         return r;
      endfunction

      function void restart();
         phase = PH_HEADER;
         hdr_count = '0;
         hdr_len = '0;
         hdr_crc = '0;
         crc = CRC_INIT;
         left = '0;
      endfunction

      // returns 0 for a byte dropped in the error phase
      function bit note_request(logic fn, logic [7:0] b);
         result_type r;
         r = '0;
         if (fn == FUNC_END) begin
            r.last = 1'b1;
            if (phase == PH_HEADER) begin
               r.status = (hdr_count == 0) ? STATUS_END : STATUS_TRUNC;
               pending.push_back(r);
            end else if (phase == PH_PAYLOAD) begin
               r.status = STATUS_TRUNC;
               r.record_length = hdr_len[LEN_W-1:0];
               pending.push_back(r);
            end
            restart();
            return 1'b1;
         end
         case (phase)
            PH_HEADER: begin
               if (hdr_count < 4) hdr_len = {b, hdr_len[31:8]};
               else hdr_crc = {b, hdr_crc[31:8]};
               if (hdr_count != HDR_LAST) begin
                  hdr_count++;
               end else begin
                  hdr_count = '0;
                  if (hdr_len == 0 || hdr_len > 32'(max_len) || hdr_len > HARD_MAX_LEN) begin
                     phase = PH_ERROR;
                     r.last = 1'b1;
                     r.status = STATUS_BAD_LEN;
                     r.record_length = hdr_len[LEN_W-1:0];
                     pending.push_back(r);
                  end else begin
                     phase = PH_PAYLOAD;
                     left = hdr_len[LEN_W-1:0];
                     crc = CRC_INIT;
                  end
               end
            end
            PH_PAYLOAD: begin
               crc = crc_step(crc, b);
               left = left - 1'b1;
               r.payload_byte = b;
               r.payload_valid = 1'b1;
               r.record_length = hdr_len[LEN_W-1:0];
               if (left != 0) begin
                  r.status = STATUS_BUSY;
               end else begin
                  r.last = 1'b1;
                  if (~crc == hdr_crc) begin
                     r.status = STATUS_GOOD;
                     restart();
                  end else begin
                     r.status = STATUS_CRC_ERR;
                     phase = PH_ERROR;
                  end
               end
               pending.push_back(r);
            end
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [7:0] pb, logic pv, logic lst, logic [2:0] st,
                                 logic [LEN_W-1:0] len);
         result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, got status %0d length %0d",
                     $time, st, len);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare("payload_byte", 32'(want.payload_byte), 32'(pb));
         compare("payload_valid", 32'(want.payload_valid), 32'(pv));
         compare("last", 32'(want.last), 32'(lst));
         compare("status", 32'(want.status), 32'(st));
         compare("record_length", 32'(want.record_length), 32'(len));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic [0:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [39:0] rsp_tdata;
   logic rsp_tlast;
   logic [3:0] rsp_tuser;
   logic csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   record_scoreboard board;
   bit steady;
   int unsigned items_sent;
   int unsigned cycles;

   crc32_record_deframer u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata[7:0], rsp_tuser[0], rsp_tlast, rsp_tuser[3:1],
                            rsp_tdata[33:8]);
      rsp_tready <= steady || ($urandom_range(99) >= 27);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_item(input logic fn, input logic [7:0] b);
      while (!steady && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (board.note_request(fn, b)) items_sent++;
   endtask

   task automatic send_end();
      send_item(FUNC_END, 8'($urandom));
   endtask

   task automatic send_header(input logic [31:0] len, input logic [31:0] sum);
      for (int i = 0; i < 4; i++) send_item(FUNC_DATA, len[8*i +: 8]);
      for (int i = 0; i < 4; i++) send_item(FUNC_DATA, sum[8*i +: 8]);
   endtask

   task automatic send_record(input int unsigned len, input record_kind_type kind);
      logic [7:0] body[$];
      logic [31:0] sum;
      int unsigned n;
      sum = CRC_INIT;
      for (int unsigned i = 0; i < len; i++) begin
         body.push_back(8'($urandom));
         sum = record_scoreboard::crc_step(sum, body[i]);
      end
      sum = ~sum;
      if (kind == REC_BAD_CRC) sum ^= 32'd1 << $urandom_range(31);
      send_header(len, sum);
      n = (kind == REC_CUT_SHORT) ? $urandom_range(len - 1, 0) : len;
      for (int unsigned i = 0; i < n; i++) send_item(FUNC_DATA, body[i]);
      if (kind == REC_CUT_SHORT) send_end();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(12, 1)) send_item(FUNC_DATA, 8'($urandom));
   endtask

   function automatic int unsigned pick_length();
      int unsigned cap;
      cap = ($urandom_range(9) == 0) ? 64 : 12;
      if (board.max_len < cap) cap = 32'(board.max_len);
      return $urandom_range(cap, 1);
   endfunction

   function automatic logic [31:0] pick_bad_length();
      logic [31:0] m;
      m = 32'(board.max_len);
      case ($urandom_range(4))
         0: return 32'd0;
         1: return m + 1;
         2: return m + 1 + $urandom_range(1000);
         3: return $urandom | 32'h0400_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic send_scenario();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_record(pick_length(), REC_GOOD);
      end else if (pick < 63) begin
         send_record(pick_length(), REC_BAD_CRC);
         send_noise();
         send_end();
      end else if (pick < 71) begin
         send_header(pick_bad_length(), $urandom);
         send_noise();
         send_end();
      end else if (pick < 78) begin
         send_record(pick_length(), REC_CUT_SHORT);
      end else if (pick < 84) begin
         repeat ($urandom_range(7, 1)) send_item(FUNC_DATA, 8'($urandom));
         send_end();
      end else if (pick < 90) begin
         send_end();
      end else if (pick < 93) begin
         // longest accepted length, followed by up to three bytes and an end marker
         send_header(32'(board.max_len), $urandom);
         repeat ($urandom_range(3)) send_item(FUNC_DATA, 8'($urandom));
         send_end();
      end else begin
         send_noise();
         send_end();
      end
   endtask

   // only with the block idle: nothing owed and the pipe flushed
   task automatic write_max_len(input logic [LEN_W-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.max_len = value;
   endtask

   initial begin
      logic [LEN_W-1:0] settings[4];
      board = new();
      steady = 1'b0;
      items_sent = 0;
      cycles = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      rsp_tready <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      settings[0] = MAX_LEN_RESET;
      settings[1] = 26'd1;
      settings[2] = 26'($urandom_range(40, 2));
      settings[3] = MAX_LEN_RESET - 1'b1;

      write_max_len(settings[0]);
      send_end();
      send_header(32'd1, ~record_scoreboard::crc_step(CRC_INIT, 8'hFF));
      send_item(FUNC_DATA, 8'hFF);
      repeat (3) send_item(FUNC_DATA, 8'h00);
      send_end();
      // zero length, then a dropped byte and a silent end
      send_header(32'd0, 32'd0);
      send_item(FUNC_DATA, 8'h00);
      send_end();

      for (int s = 0; s < 4; s++) begin
         int unsigned stop_at;
         if (s > 0) write_max_len(settings[s]);
         steady = (s == 2);
         stop_at = items_sent + ITEMS_PER_SETTING;
         while (items_sent < stop_at) send_scenario();
      end
      steady = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
